### hw/rtl/qsi_pkg.sv
// Shared constants and the CORDIC arc table for the quintic segment interpolator.
// Used by qsi_cordic, qsi_divider, qsi_core and the top level; depends on nothing.
`default_nettype none

package qsi_pkg;

  localparam int MAX_STEPS         = 63;
  localparam int MAX_SEGMENTS      = 1024;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int SEG_CAP = ((MAX_SEGMENTS - 1) > 1023) ? 1023 : (MAX_SEGMENTS - 1);

  localparam int POS_W  = 24;
  localparam int HEAD_W = 16;
  localparam int SEG_W  = 10;
  localparam int STEP_W = 6;
  localparam int ITER_W = 5;
  localparam int TRIG_W = 34;
  localparam int VEL_W  = 26;
  localparam int COEF_W = 33;
  localparam int ACC_W  = 64;
  localparam int DEN_W  = 31;
  localparam int QUO_BITS = 23;

  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

  function automatic logic [31:0] arc_angle(input logic [ITER_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2E;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/qsi_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a 16-bit heading in Q3.30.
// Depends on qsi_pkg.
`default_nettype none

module qsi_cordic (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [qsi_pkg::HEAD_W-1:0]         heading,
  output logic                                    done,
  output logic signed [qsi_pkg::TRIG_W-1:0]       sin_val,
  output logic signed [qsi_pkg::TRIG_W-1:0]       cos_val
);

  localparam logic signed [qsi_pkg::TRIG_W-1:0] HALF    = qsi_pkg::TRIG_W'(64'sd2147483648);
  localparam logic signed [qsi_pkg::TRIG_W-1:0] QUARTER = qsi_pkg::TRIG_W'(64'sd1073741824);

  logic                              busy;
  logic                              flip;
  logic [qsi_pkg::ITER_W-1:0]        iter;
  logic signed [qsi_pkg::TRIG_W-1:0] x, y, z;
  logic signed [31:0]                z_raw;
  logic signed [qsi_pkg::TRIG_W-1:0] z_ext, z_fold, dx, dy, arc;
  logic                              fold;

  always_comb begin
    z_raw = $signed({heading, 16'b0});
    z_ext = qsi_pkg::TRIG_W'(z_raw);
    fold  = 1'b0;
    z_fold = z_ext;
    if (z_ext > QUARTER) begin
      z_fold = z_ext - HALF;
      fold   = 1'b1;
    end else if (z_ext < -QUARTER) begin
      z_fold = z_ext + HALF;
      fold   = 1'b1;
    end
    dx  = y >>> iter;
    dy  = x >>> iter;
    arc = $signed({2'b00, qsi_pkg::arc_angle(iter)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == qsi_pkg::ITER_W'(qsi_pkg::CORDIC_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= $signed({2'b00, qsi_pkg::CORDIC_GAIN_INV});
      y    <= '0;
      z    <= z_fold;
      flip <= fold;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - arc;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + arc;
      end
    end
  end

  assign sin_val = flip ? -y : y;
  assign cos_val = flip ? -x : x;

endmodule

`default_nettype wire

### hw/rtl/qsi_divider.sv
// Bit-serial divider giving the rounded point value floor(num / den) saturated to Q15.8.
// Depends on qsi_pkg.
`default_nettype none

module qsi_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [qsi_pkg::ACC_W-1:0]  num,
  input  wire logic [qsi_pkg::DEN_W-1:0]         den,
  output logic                                   done,
  output logic signed [qsi_pkg::POS_W-1:0]       quo
);

  localparam int REM_W = qsi_pkg::DEN_W + qsi_pkg::QUO_BITS;
  localparam int DSH_W = REM_W - 1;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_ABS  = 3'd1;
  localparam logic [2:0] D_CMP  = 3'd2;
  localparam logic [2:0] D_RUN  = 3'd3;
  localparam logic [2:0] D_FIN  = 3'd4;

  logic [2:0]                        phase;
  logic signed [qsi_pkg::ACC_W-1:0]  num_r, neg_num;
  logic                              neg, sat;
  logic [qsi_pkg::ACC_W-2:0]         mag, limit;
  logic [REM_W-1:0]                  rem;
  logic [DSH_W-1:0]                  dsh;
  logic [qsi_pkg::QUO_BITS-1:0]      q;
  logic [4:0]                        cnt;
  logic                              fits;
  logic [qsi_pkg::QUO_BITS+1:0]      qinc, qneg;

  always_comb begin
    neg_num = -num_r;
    limit   = (qsi_pkg::ACC_W-1)'({den, qsi_pkg::QUO_BITS'(0)});
    fits    = rem >= {1'b0, dsh};
    qinc    = {2'b00, q} + {{(qsi_pkg::QUO_BITS+1){1'b0}}, (rem != '0)};
    qneg    = -qinc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        D_IDLE: begin
          if (start) begin
            num_r <= num;
            phase <= D_ABS;
          end
        end
        D_ABS: begin
          neg   <= num_r[qsi_pkg::ACC_W-1];
          mag   <= num_r[qsi_pkg::ACC_W-1] ? neg_num[qsi_pkg::ACC_W-2:0]
                                           : num_r[qsi_pkg::ACC_W-2:0];
          phase <= D_CMP;
        end
        D_CMP: begin
          if (mag >= limit) begin
            sat   <= 1'b1;
            phase <= D_FIN;
          end else begin
            sat   <= 1'b0;
            rem   <= mag[REM_W-1:0];
            dsh   <= DSH_W'({den, (qsi_pkg::QUO_BITS-1)'(0)});
            q     <= '0;
            cnt   <= '0;
            phase <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) begin
            rem <= rem - {1'b0, dsh};
          end
          q   <= {q[qsi_pkg::QUO_BITS-2:0], fits};
          dsh <= dsh >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == 5'(qsi_pkg::QUO_BITS - 1)) begin
            phase <= D_FIN;
          end
        end
        D_FIN: begin
          if (sat) begin
            quo <= neg ? {1'b1, {(qsi_pkg::POS_W-1){1'b0}}} : {1'b0, {(qsi_pkg::POS_W-1){1'b1}}};
          end else if (neg) begin
            quo <= qneg[qsi_pkg::POS_W-1:0];
          end else begin
            quo <= {1'b0, q};
          end
          done  <= 1'b1;
          phase <= D_IDLE;
        end
        default: phase <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qsi_core.sv
// Sequencer, shared multiplier and Horner accumulator of the quintic segment interpolator.
// Depends on qsi_pkg, qsi_cordic and qsi_divider.
`default_nettype none

module qsi_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [qsi_pkg::STEP_W-1:0]        steps,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [qsi_pkg::POS_W-1:0]  in_x,
  input  wire logic signed [qsi_pkg::POS_W-1:0]  in_y,
  input  wire logic [qsi_pkg::HEAD_W-1:0]        in_head,
  input  wire logic signed [qsi_pkg::POS_W-1:0]  in_speed,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [qsi_pkg::POS_W-1:0]       out_x,
  output logic signed [qsi_pkg::POS_W-1:0]       out_y,
  output logic [qsi_pkg::SEG_W-1:0]              out_seg,
  output logic                                   out_last
);

  localparam int PW = qsi_pkg::POS_W;
  localparam int TW = qsi_pkg::TRIG_W;
  localparam int AW = qsi_pkg::ACC_W;
  localparam int SW = qsi_pkg::STEP_W;
  localparam int CW = qsi_pkg::COEF_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_C0S   = 4'd1;
  localparam logic [3:0] ST_C0W   = 4'd2;
  localparam logic [3:0] ST_C1S   = 4'd3;
  localparam logic [3:0] ST_C1W   = 4'd4;
  localparam logic [3:0] ST_SETUP = 4'd5;
  localparam logic [3:0] ST_HORN  = 4'd6;
  localparam logic [3:0] ST_PREP  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  localparam logic [4:0] SETUP_LAST = 5'd18;
  localparam logic [2:0] HORN_LAST  = 3'd4;

  logic [3:0]                      state;
  logic signed [PW-1:0]            prev_x, prev_y, prev_sp, new_x, new_y, new_sp;
  logic [qsi_pkg::HEAD_W-1:0]      prev_head, new_head;
  logic                            have_prev, new_last;
  logic [qsi_pkg::SEG_W-1:0]       seg_idx;
  logic [SW-1:0]                   s, top, i, s_eff;
  logic [4:0]                      st;
  logic [2:0]                      hk;
  logic                            coord;
  logic signed [TW-1:0]            sin0, cos0, sin1, cos1;
  logic signed [2*TW-1:0]          prod, prod_rnd;
  logic [11:0]                     s2;
  logic [17:0]                     s3;
  logic [23:0]                     s4;
  logic [29:0]                     s5;
  logic signed [qsi_pkg::VEL_W-1:0] v0x, v0y, v1x, v1y;
  logic signed [CW-1:0]            ux, uy, wx, wy;
  logic signed [qsi_pkg::COEF_W-1:0] ax3, ax4, ax5, ay3, ay4, ay5;
  logic signed [qsi_pkg::COEF_W-1:0] a3x_c, a4x_c, a5x_c, a3y_c, a4y_c, a5y_c;
  logic signed [AW-1:0]            bx0, bx1, bx3, bx4, by0, by1, by3, by4;
  logic signed [AW-1:0]            n, hsel, horner_next, div_num;
  logic signed [PW-1:0]            px, py;
  logic signed [TW-1:0]            mul_a, mul_b;
  logic                            cor_start, cor_done;
  logic signed [TW-1:0]            cor_sin, cor_cos;
  logic                            div_done;
  logic signed [PW-1:0]            div_quo;
  logic                            emit_fire;

  qsi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .heading ((state == ST_C0S) ? prev_head : new_head),
    .done    (cor_done),
    .sin_val (cor_sin),
    .cos_val (cor_cos)
  );

  qsi_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .num   (div_num),
    .den   ({s5, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cor_start = (state == ST_C0S) || (state == ST_C1S);
  assign in_ready  = (state == ST_IDLE);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    s_eff = (steps == '0) ? SW'(1) : steps;
    if (steps > SW'(qsi_pkg::MAX_STEPS)) begin
      s_eff = SW'(qsi_pkg::MAX_STEPS);
    end
    ux = CW'(new_x) - CW'(prev_x) - CW'(v0x);
    wx = CW'(v1x) - CW'(v0x);
    uy = CW'(new_y) - CW'(prev_y) - CW'(v0y);
    wy = CW'(v1y) - CW'(v0y);
    a3x_c = (ux <<< 3) + (ux <<< 1) - (wx <<< 2);
    a4x_c = (wx <<< 3) - wx - (ux <<< 4) + ux;
    a5x_c = (ux <<< 2) + (ux <<< 1) - (wx <<< 1) - wx;
    a3y_c = (uy <<< 3) + (uy <<< 1) - (wy <<< 2);
    a4y_c = (wy <<< 3) - wy - (uy <<< 4) + uy;
    a5y_c = (uy <<< 2) + (uy <<< 1) - (wy <<< 1) - wy;
    prod_rnd = prod + (2*TW)'(64'sd536870912);
    case (hk)
      3'd0:    hsel = coord ? by4 : bx4;
      3'd1:    hsel = coord ? by3 : bx3;
      3'd3:    hsel = coord ? by1 : bx1;
      3'd4:    hsel = coord ? by0 : bx0;
      default: hsel = '0;
    endcase
    horner_next = n * $signed({{(AW-SW){1'b0}}, i}) + hsel;
    div_num     = (n <<< 1) + $signed({{(AW-30){1'b0}}, s5});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      5'd0:  begin mul_a = $signed({{(TW-SW){1'b0}}, s});  mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd1:  begin mul_a = TW'(prev_sp);                   mul_b = sin0; end
      5'd2:  begin mul_a = $signed({{(TW-12){1'b0}}, s2}); mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd3:  begin mul_a = TW'(prev_sp);                   mul_b = cos0; end
      5'd4:  begin mul_a = $signed({{(TW-18){1'b0}}, s3}); mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd5:  begin mul_a = TW'(new_sp);                    mul_b = sin1; end
      5'd6:  begin mul_a = $signed({{(TW-24){1'b0}}, s4}); mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd7:  begin mul_a = TW'(new_sp);                    mul_b = cos1; end
      5'd10: begin mul_a = TW'(ax4);   mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd11: begin mul_a = TW'(ax3);   mul_b = $signed({{(TW-12){1'b0}}, s2}); end
      5'd12: begin mul_a = TW'(v0x);   mul_b = $signed({{(TW-24){1'b0}}, s4}); end
      5'd13: begin mul_a = TW'(prev_x); mul_b = $signed({{(TW-30){1'b0}}, s5}); end
      5'd14: begin mul_a = TW'(ay4);   mul_b = $signed({{(TW-SW){1'b0}}, s}); end
      5'd15: begin mul_a = TW'(ay3);   mul_b = $signed({{(TW-12){1'b0}}, s2}); end
      5'd16: begin mul_a = TW'(v0y);   mul_b = $signed({{(TW-24){1'b0}}, s4}); end
      5'd17: begin mul_a = TW'(prev_y); mul_b = $signed({{(TW-30){1'b0}}, s5}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      have_prev <= 1'b0;
      seg_idx   <= '0;
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_sp   <= '0;
      prev_head <= '0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
        out_x     <= px;
        out_y     <= py;
        out_seg   <= seg_idx;
        out_last  <= (i == top);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            new_x    <= in_x;
            new_y    <= in_y;
            new_head <= in_head;
            new_sp   <= in_speed;
            new_last <= in_last;
            s        <= s_eff;
            top      <= in_last ? s_eff : s_eff - 1'b1;
            i        <= '0;
            if (have_prev) begin
              state <= ST_C0S;
            end else begin
              prev_x    <= in_x;
              prev_y    <= in_y;
              prev_head <= in_head;
              prev_sp   <= in_speed;
              have_prev <= !in_last;
            end
          end
        end
        ST_C0S: state <= ST_C0W;
        ST_C0W: begin
          if (cor_done) begin
            sin0  <= cor_sin;
            cos0  <= cor_cos;
            state <= ST_C1S;
          end
        end
        ST_C1S: state <= ST_C1W;
        ST_C1W: begin
          if (cor_done) begin
            sin1  <= cor_sin;
            cos1  <= cor_cos;
            st    <= '0;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          prod <= mul_a * mul_b;
          st   <= st + 1'b1;
          case (st)
            5'd1:  s2  <= prod[11:0];
            5'd2:  v0x <= prod_rnd[55:30];
            5'd3:  s3  <= prod[17:0];
            5'd4:  v0y <= prod_rnd[55:30];
            5'd5:  s4  <= prod[23:0];
            5'd6:  v1x <= prod_rnd[55:30];
            5'd7:  s5  <= prod[29:0];
            5'd8:  v1y <= prod_rnd[55:30];
            5'd9: begin
              ax3 <= a3x_c;
              ax4 <= a4x_c;
              ax5 <= a5x_c;
              ay3 <= a3y_c;
              ay4 <= a4y_c;
              ay5 <= a5y_c;
            end
            5'd11: bx4 <= prod[AW-1:0];
            5'd12: bx3 <= prod[AW-1:0];
            5'd13: bx1 <= prod[AW-1:0];
            5'd14: bx0 <= prod[AW-1:0];
            5'd15: by4 <= prod[AW-1:0];
            5'd16: by3 <= prod[AW-1:0];
            5'd17: by1 <= prod[AW-1:0];
            5'd18: by0 <= prod[AW-1:0];
            default: ;
          endcase
          if (st == SETUP_LAST) begin
            n     <= AW'(ax5);
            hk    <= '0;
            coord <= 1'b0;
            state <= ST_HORN;
          end
        end
        ST_HORN: begin
          n  <= horner_next;
          hk <= hk + 1'b1;
          if (hk == HORN_LAST) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            if (!coord) begin
              px    <= div_quo;
              coord <= 1'b1;
              n     <= AW'(ay5);
              hk    <= '0;
              state <= ST_HORN;
            end else begin
              py    <= div_quo;
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (i == top) begin
              prev_x    <= new_x;
              prev_y    <= new_y;
              prev_head <= new_head;
              prev_sp   <= new_sp;
              have_prev <= !new_last;
              if (new_last) begin
                seg_idx <= '0;
              end else if (seg_idx < qsi_pkg::SEG_W'(qsi_pkg::SEG_CAP)) begin
                seg_idx <= seg_idx + 1'b1;
              end
              state <= ST_IDLE;
            end else begin
              i     <= i + 1'b1;
              coord <= 1'b0;
              n     <= AW'(ax5);
              hk    <= '0;
              state <= ST_HORN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/quintic_segment_interpolator_top.sv
// Top level of the quintic segment interpolator: stream ports, step register and core.
// Depends on qsi_pkg and qsi_core.
//
// Waypoints enter one transfer at a time and each one after the first of a path yields
// steps_per_segment points, plus the end point when tlast marks the final waypoint.
// The block takes one waypoint at a time: a waypoint that opens a path is only stored,
// and any other first runs a setup (two CORDIC runs, each after its start state, and 19
// steps on the shared 34 x 34 multiplier) and then computes each point with the five-step
// Horner pass and the one-bit-per-cycle divider, each run once for x and once for y; a
// coordinate that saturates skips the 23 divide steps. A finished point waits in the
// output register while the next one is computed, and a point that is still waiting there
// when the next one is ready holds the block until it is taken.
`default_nettype none

module quintic_segment_interpolator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,   // pos_x, pos_y, heading, speed
  input  wire logic        s_axis_tlast,   // last_waypoint
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // point_x, point_y, segment, zero fill
  output logic             m_axis_tlast    // last_point
);

  logic [qsi_pkg::STEP_W-1:0]             steps;
  logic signed [qsi_pkg::POS_W-1:0]       point_x, point_y;
  logic [qsi_pkg::SEG_W-1:0]              segment;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= qsi_pkg::STEP_W'(16);
    end else if (cfg_wr_en) begin
      steps <= cfg_wr_data;
    end
  end

  qsi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .steps     (steps),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      ($signed(s_axis_tdata[23:0])),
    .in_y      ($signed(s_axis_tdata[47:24])),
    .in_head   (s_axis_tdata[63:48]),
    .in_speed  ($signed(s_axis_tdata[87:64])),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (point_x),
    .out_y     (point_y),
    .out_seg   (segment),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, segment, point_y, point_x};

endmodule

`default_nettype wire

### hw/rtl/qsi_checker.sv
// Port-level checks for the quintic segment interpolator, bound to its top level.
// Depends on quintic_segment_interpolator_top's port list only.
`default_nettype none

module qsi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output valid dropped before the transfer.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Output payload changed while stalled.");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:58] == 6'b0)
    else $error("Output fill bits are not zero.");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("Input accepted while a segment is still being produced.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind quintic_segment_interpolator_top qsi_checker u_qsi_checker (.*);

`default_nettype wire

### tb/quintic_segment_interpolator_top_tb.sv
// Self-checking testbench for quintic_segment_interpolator_top: waypoint transfers in, points out.
// It uses qsi_pkg for its limits and CORDIC constants and predicts every point with its own CORDIC and quintic model.
`timescale 1ns / 100ps
`default_nettype none

module quintic_segment_interpolator_top_tb;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [9:0]  seg;
    logic        lastp;
  } point_t;

  localparam longint CYCLE_LIMIT = 10000000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [31:0] ARC [0:15] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // pos_x, pos_y, heading, speed
  logic        s_axis_tlast;   // last_waypoint
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // point_x, point_y, segment, zero fill
  logic        m_axis_tlast;   // last_point

  point_t      pending_points[$];
  int          errors;
  int          snd_pct;
  int          rcv_pct;
  longint      cycles = 0;

  logic [5:0]  steps_reg;
  logic [23:0] wp_x, wp_y, wp_speed;
  logic [15:0] wp_heading;
  logic        wp_have;
  logic [9:0]  wp_segment;

  quintic_segment_interpolator_top DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic sin_cos(input logic [15:0] h, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({h, 16'h0000});
    x = longint'(qsi_pkg::CORDIC_GAIN_INV);
    y = 0;
    flip = 0;
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1;
    end
    for (int i = 0; i < qsi_pkg::CORDIC_ITERATIONS && i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = y;
    cs = x;
  endtask

  function automatic longint velocity(input longint sp, input longint q30);
    return (sp * q30 + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [23:0] quintic_at(input longint p0, input longint v0,
                                             input longint p1, input longint v1,
                                             input longint i, input longint s);
    longint u, v, a3, a4, a5, s2, s3, s4, s5, n, num, den, q;
    u = p1 - p0 - v0;
    v = v1 - v0;
    a3 = 10 * u - 4 * v;
    a4 = -15 * u + 7 * v;
    a5 = 6 * u - 3 * v;
    s2 = s * s; s3 = s2 * s; s4 = s3 * s; s5 = s4 * s;
    n = a5;
    n = n * i + a4 * s;
    n = n * i + a3 * s2;
    n = n * i;
    n = n * i + v0 * s4;
    n = n * i + p0 * s5;
    num = 2 * n + s5;
    den = 2 * s5;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    if (q < -64'sd8388608) q = -64'sd8388608;
    if (q > 64'sd8388607) q = 64'sd8388607;
    return q[23:0];
  endfunction

  task automatic predict_points(input logic [23:0] px, input logic [23:0] py,
                                input logic [15:0] hd, input logic [23:0] sp,
                                input logic lastw);
    longint s, sn0, cs0, sn1, cs1, top, x0, y0, x1, y1, vsp, psp;
    point_t pt;
    if (wp_have) begin
      s = steps_reg;
      if (s < 1) s = 1;
      if (s > qsi_pkg::MAX_STEPS) s = qsi_pkg::MAX_STEPS;
      sin_cos(wp_heading, sn0, cs0);
      sin_cos(hd, sn1, cs1);
      psp = longint'(signed'(wp_speed));
      vsp = longint'(signed'(sp));
      x0 = longint'(signed'(wp_x));
      y0 = longint'(signed'(wp_y));
      x1 = longint'(signed'(px));
      y1 = longint'(signed'(py));
      top = lastw ? s : s - 1;
      for (longint i = 0; i <= top; i++) begin
        pt.x = quintic_at(x0, velocity(psp, sn0), x1, velocity(vsp, sn1), i, s);
        pt.y = quintic_at(y0, velocity(psp, cs0), y1, velocity(vsp, cs1), i, s);
        pt.seg = wp_segment;
        pt.lastp = (i == top);
        pending_points = {pending_points, pt};
      end
      if (wp_segment < qsi_pkg::SEG_CAP) wp_segment++;
    end
    wp_have = !lastw;
    if (lastw) wp_segment = '0;
    wp_x = px;
    wp_y = py;
    wp_heading = hd;
    wp_speed = sp;
  endtask

  task automatic send_waypoint(input logic [23:0] px, input logic [23:0] py,
                               input logic [15:0] hd, input logic [23:0] sp,
                               input logic lastw);
    @(negedge clk);
    if ($urandom_range(99) < snd_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_axis_tdata <= {sp, hd, py, px};
    s_axis_tlast <= lastw;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_points(px, py, hd, sp, lastw);
  endtask

  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_steps(input logic [5:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    steps_reg = value;
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h", what, got, want);
  endtask

  function automatic logic [23:0] rand_pos();
    if ($urandom_range(3) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(8000)) - 4000);
  endfunction

  task automatic test_directed;
    send_waypoint(24'h001000, 24'h002000, 16'h4000, 24'h000100, 1'b1);
    send_waypoint(24'h7FFFFF, 24'h800000, 16'h0000, 24'h7FFFFF, 1'b0);
    send_waypoint(24'h800000, 24'h7FFFFF, 16'h4000, 24'h800000, 1'b0);
    send_waypoint(24'h000000, 24'h000000, 16'h8000, 24'h000400, 1'b0);
    send_waypoint(24'h000800, 24'hFFF800, 16'hC000, 24'hFFFC00, 1'b0);
    send_waypoint(24'hFFFFFF, 24'h000001, 16'hFFFF, 24'h000200, 1'b0);
    send_waypoint(24'h001234, 24'h004321, 16'h2000, 24'h000300, 1'b1);
    send_waypoint(24'h000100, 24'h000100, 16'h6000, 24'h000100, 1'b0);
    send_waypoint(24'h000300, 24'h000500, 16'hA000, 24'h000080, 1'b1);
  endtask

  task automatic test_step_extremes;
    logic [5:0] settings [4] = '{6'd0, 6'd1, 6'd63, 6'd2};
    foreach (settings[k]) begin
      set_steps(settings[k]);
      send_waypoint(rand_pos(), rand_pos(), 16'($urandom), 24'h000100, 1'b0);
      send_waypoint(rand_pos(), rand_pos(), 16'($urandom), 24'hFFFF00, 1'b0);
      send_waypoint(rand_pos(), rand_pos(), 16'($urandom), 24'h000200, 1'b1);
    end
  endtask

  task automatic test_random_paths(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      set_steps(($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(8, 1)));
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        send_waypoint(rand_pos(), rand_pos(), 16'($urandom),
                      ($urandom_range(3) == 0) ? 24'($urandom) : rand_pos(),
                      (k == len - 1) ? 1'b1 : ($urandom_range(19) == 0));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= rcv_pct);
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point_x", m_axis_tdata[23:0], 24'h000000);
      end else begin
        want = pending_points.pop_front();
        if (m_axis_tdata[23:0] !== want.x) report_mismatch("point_x", m_axis_tdata[23:0], want.x);
        if (m_axis_tdata[47:24] !== want.y)
          report_mismatch("point_y", m_axis_tdata[47:24], want.y);
        if (m_axis_tdata[57:48] !== want.seg)
          report_mismatch("segment", 24'(m_axis_tdata[57:48]), 24'(want.seg));
        if (m_axis_tlast !== want.lastp)
          report_mismatch("last_point", 24'(m_axis_tlast), 24'(want.lastp));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quintic_segment_interpolator_top verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    steps_reg = 6'd16;
    wp_x = '0; wp_y = '0; wp_heading = '0; wp_speed = '0;
    wp_have = 1'b0;
    wp_segment = '0;
    snd_pct = 34;
    rcv_pct = 80;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_step_extremes();
    test_random_paths(130);
    snd_pct = 80;
    rcv_pct = 34;
    test_random_paths(130);
    snd_pct = 0;
    rcv_pct = 0;
    test_random_paths(130);
    drain();
    if (errors == 0) begin
      $display("quintic_segment_interpolator_top verification clean");
    end else begin
      $display("quintic_segment_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/qsi_pkg.sv
hw/rtl/qsi_cordic.sv
hw/rtl/qsi_divider.sv
hw/rtl/qsi_core.sv
hw/rtl/quintic_segment_interpolator_top.sv
hw/rtl/qsi_checker.sv
tb/quintic_segment_interpolator_top_tb.sv
